>>> rtl/rpn_stack_evaluator_macros.svh
// Assertion macros for the datapath (rpn_dp) of the stack evaluator.
`ifndef RPN_STACK_EVALUATOR_MACROS_SVH
`define RPN_STACK_EVALUATOR_MACROS_SVH

`ifndef SYNTH

`define RPN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`define RPN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RPN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`define RPN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/rpn_pkg.sv
`default_nettype none

package rpn_pkg;

  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH_W     = 7;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int STEP_W      = $clog2(DATA_W);

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic                push;
    logic                rd_issue;
    logic                alu_load;
    logic                div_start;
    logic                div_take;
    logic                commit;
    logic                out_load;
    logic [CMD_W-1:0]    op;
    logic [STATUS_W-1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic ge2;
    logic top_zero;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/rpn_ram.sv
`default_nettype none

module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/rpn_div.sv
`default_nettype none

module rpn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rpn_pkg::DATA_W-1:0] dividend,
  input  logic [rpn_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [rpn_pkg::DATA_W-1:0] quotient
);

  localparam int W = rpn_pkg::DATA_W;

  logic                     busy_r, busy_nxt;
  logic                     fin_r, fin_nxt;
  logic [rpn_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]             rem_r, rem_nxt;
  logic [W-1:0]             quo_r, quo_nxt;
  logic [W-1:0]             dvs_r, dvs_nxt;
  logic                     neg_r, neg_nxt;
  logic [W:0]               shifted;
  logic [W:0]               diff;
  logic                     ge;

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend[W-1] ? (W'(0) - dividend) : dividend;
      dvs_nxt  = divisor[W-1] ? (W'(0) - divisor) : divisor;
      neg_nxt  = dividend[W-1] ^ divisor[W-1];
    end else if (busy_r) begin
      rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], ge};
      cnt_nxt = cnt_r + rpn_pkg::STEP_W'(1);
      if (cnt_r == rpn_pkg::STEP_W'(W - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = fin_r;
  assign quotient = neg_r ? (W'(0) - quo_r) : quo_r;

endmodule

`default_nettype wire

>>> rtl/rpn_dp.sv
`default_nettype none
`include "rpn_stack_evaluator_macros.svh"

module rpn_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rpn_pkg::dp_cmd_t              cmd_i,
  output rpn_pkg::dp_sts_t              sts_o,
  input  logic [rpn_pkg::DATA_W-1:0]    operand,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rpn_pkg::STATUS_W-1:0]  out_status,
  output logic [rpn_pkg::DATA_W-1:0]    out_top_value,
  output logic [rpn_pkg::DEPTH_W-1:0]   out_depth
);

  localparam int W     = rpn_pkg::DATA_W;
  localparam int CNT_W = rpn_pkg::CNT_W;
  localparam int AW    = rpn_pkg::ADDR_W;

  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [W-1:0]                  top_r, top_nxt;
  logic [W-1:0]                  res_r, res_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [rpn_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [W-1:0]                  out_top_r, out_top_nxt;
  logic [rpn_pkg::DEPTH_W-1:0]   out_depth_r, out_depth_nxt;

  logic [CNT_W-1:0] count_m2;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [W-1:0]     ram_wdata;
  logic [W-1:0]     ram_rdata;
  logic [W-1:0]     alu_res;
  logic [2*W-1:0]   prod;
  logic             div_done;
  logic [W-1:0]     div_quo;
  logic             out_free;

  assign count_m2 = count_r - CNT_W'(2);
  assign out_free = !out_valid_r || !out_stall;

  assign ram_we    = cmd_i.push || cmd_i.commit;
  assign ram_waddr = cmd_i.push ? count_r[AW-1:0] : count_m2[AW-1:0];
  assign ram_wdata = cmd_i.push ? operand : res_r;

  rpn_ram #(
    .WIDTH (W),
    .DEPTH (rpn_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd_i.rd_issue),
    .raddr (count_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd_i.div_start),
    .dividend (ram_rdata),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign prod = ram_rdata * top_r;

  always_comb begin
    case (cmd_i.op)
      rpn_pkg::CMD_SUB: alu_res = ram_rdata - top_r;
      rpn_pkg::CMD_MUL: alu_res = prod[W-1:0];
      default:          alu_res = ram_rdata + top_r;
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    top_nxt        = top_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    if (cmd_i.push) begin
      count_nxt = count_r + CNT_W'(1);
      top_nxt   = operand;
    end
    if (cmd_i.alu_load) begin
      res_nxt = alu_res;
    end
    if (cmd_i.div_take) begin
      res_nxt = div_quo;
    end
    if (cmd_i.commit) begin
      count_nxt = count_r - CNT_W'(1);
      top_nxt   = res_r;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = cmd_i.status;
      out_top_nxt    = (count_r != '0) ? top_r : '0;
      out_depth_nxt  = rpn_pkg::DEPTH_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_r        <= top_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  assign sts_o.full     = count_r == CNT_W'(rpn_pkg::STACK_DEPTH);
  assign sts_o.ge2      = count_r >= CNT_W'(2);
  assign sts_o.top_zero = top_r == '0;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = out_free;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_top_value = out_top_r;
  assign out_depth     = out_depth_r;

  `RPN_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(rpn_pkg::STACK_DEPTH), "Stack count exceeds the stack depth.")
  `RPN_ASSERT_IMP(a_push_room, clk, rst_n, cmd_i.push, count_r < CNT_W'(rpn_pkg::STACK_DEPTH), "Push issued on a full stack.")
  `RPN_ASSERT_IMP(a_commit_two, clk, rst_n, cmd_i.commit, count_r >= CNT_W'(2), "Operator result written back with fewer than two elements.")
  `RPN_ASSERT_NXT(a_commit_pop, clk, rst_n, cmd_i.commit, (count_r + CNT_W'(1)) == $past(count_r), "Operator write-back did not drop the count by one.")
  `RPN_ASSERT_IMP(a_out_free, clk, rst_n, cmd_i.out_load, !out_valid_r || !out_stall, "Result register overwritten while a word is still waiting.")

endmodule

`default_nettype wire

>>> rtl/rpn_ctrl.sv
`default_nettype none

module rpn_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rpn_pkg::CMD_W-1:0]  in_command,
  input  rpn_pkg::dp_sts_t           sts_i,
  output rpn_pkg::dp_cmd_t           cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_OPER   = 3'd1;
  localparam logic [2:0] S_DIVW   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [rpn_pkg::CMD_W-1:0]     op_r, op_nxt;
  logic [rpn_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic                          accept;

  assign in_stall = state_r != S_IDLE;
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    cmd_o      = '0;
    cmd_o.op     = op_r;
    cmd_o.status = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_command;
          state_nxt = S_RESULT;
          unique case (in_command) inside
            rpn_pkg::CMD_PUSH: begin
              if (sts_i.full) begin
                status_nxt = rpn_pkg::ST_FULL;
              end else begin
                status_nxt = rpn_pkg::ST_OK;
                cmd_o.push = 1'b1;
              end
            end
            rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
              if (!sts_i.ge2) begin
                status_nxt = rpn_pkg::ST_UNDERFLOW;
              end else if ((in_command == rpn_pkg::CMD_DIV) && sts_i.top_zero) begin
                status_nxt = rpn_pkg::ST_DIVZERO;
              end else begin
                status_nxt     = rpn_pkg::ST_OK;
                cmd_o.rd_issue = 1'b1;
                state_nxt      = S_OPER;
              end
            end
            default: begin
              status_nxt = rpn_pkg::ST_INVALID;
            end
          endcase
        end
      end
      S_OPER: begin
        if (op_r == rpn_pkg::CMD_DIV) begin
          cmd_o.div_start = 1'b1;
          state_nxt       = S_DIVW;
        end else begin
          cmd_o.alu_load = 1'b1;
          state_nxt      = S_COMMIT;
        end
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_nxt      = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r     <= op_nxt;
    status_r <= status_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/rpn_stack_evaluator.sv
// Postfix integer calculator on a 64-entry stack of 32-bit signed values. Each input word
// is a push of in_operand or an operator (add, subtract, multiply, divide) that combines the
// element below the top with the top, and each input word yields exactly one result word with
// the status, the new top (zero when the stack is empty) and the depth. Errors (underflow,
// invalid command, divide by zero, push onto a full stack) leave the stack unchanged. One word
// is processed at a time. A push, an invalid command or any error goes from acceptance to the
// result state; add, subtract and multiply pass an operate and a write-back state first
// because the element below the top is read from the stack RAM and written back, and divide
// also waits for the divider, which resolves one quotient bit per cycle. A new word is
// accepted while the previous result still waits in the output register.
`default_nettype none

module rpn_stack_evaluator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic        [rpn_pkg::CMD_W-1:0]   in_command,
  input  logic signed [rpn_pkg::DATA_W-1:0]  in_operand,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [rpn_pkg::STATUS_W-1:0] out_status,
  output logic signed [rpn_pkg::DATA_W-1:0]  out_top_value,
  output logic        [rpn_pkg::DEPTH_W-1:0] out_depth
);

  rpn_pkg::dp_cmd_t dp_cmd;
  rpn_pkg::dp_sts_t dp_sts;

  rpn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  rpn_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .operand       (in_operand),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_top_value (out_top_value),
    .out_depth     (out_depth)
  );

endmodule

`default_nettype wire
